// File: rtl/core/art_pkg.sv
// Shared types and constants of the address region table.
// No dependencies; every module of the block but art_checker imports this package.
package art_pkg;

  localparam int SpaceW = 16;
  localparam int AddrW  = 48;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_DELETE  = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;
  localparam logic [1:0] KIND_CLEANUP = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // A request as it travels along the chain of cells.
  typedef struct packed {
    logic              active;
    logic [1:0]        kind;
    logic [SpaceW-1:0] space_id;
    logic [AddrW-1:0]  base_addr;
    logic [AddrW-1:0]  region_len;
    logic              done;
    logic              hit;
  } art_token_t;

endpackage

// File: rtl/core/art_cell.sv
// One entry of the address region table and its share of the scan.
// Depends on art_pkg.
module art_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  art_pkg::art_token_t tok_in,
  output art_pkg::art_token_t tok_out
);
  import art_pkg::*;

  logic [SpaceW-1:0] space_r;
  logic [AddrW-1:0]  base_r;
  logic [AddrW-1:0]  len_r;
  logic [SpaceW-1:0] space_nxt;
  logic [AddrW-1:0]  base_nxt;
  logic [AddrW-1:0]  len_nxt;
  art_token_t        tok_r;
  art_token_t        tok_nxt;
  logic              live;
  logic              same_id;
  logic [AddrW:0]    end_addr;

  assign live     = (len_r != '0);
  assign same_id  = (space_r == tok_in.space_id);
  assign end_addr = {1'b0, base_r} + {1'b0, len_r};

  // Act on the entry when the request passes, then hand the request on.
  always_comb begin
    space_nxt = space_r;
    base_nxt  = base_r;
    len_nxt   = len_r;
    tok_nxt   = tok_in;
    if (tok_in.active && !tok_in.done) begin
      unique case (tok_in.kind)
        KIND_ADD: begin
          if (!live) begin
            space_nxt    = tok_in.space_id;
            base_nxt     = tok_in.base_addr;
            len_nxt      = tok_in.region_len;
            tok_nxt.done = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (live && same_id && base_r == tok_in.base_addr &&
              len_r == tok_in.region_len) begin
            space_nxt    = '0;
            base_nxt     = '0;
            len_nxt      = '0;
            tok_nxt.done = 1'b1;
          end
        end
        KIND_QUERY: begin
          if (live && same_id && tok_in.base_addr >= base_r &&
              {1'b0, tok_in.base_addr} < end_addr) begin
            tok_nxt.done = 1'b1;
            tok_nxt.hit  = 1'b1;
          end
        end
        default: begin
          if (same_id) begin
            space_nxt = '0;
            base_nxt  = '0;
            len_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r      <= '0;
      base_r       <= '0;
      len_r        <= '0;
      tok_r.active <= 1'b0;
    end else begin
      space_r <= space_nxt;
      base_r  <= base_nxt;
      len_r   <= len_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/core/address_region_table.sv
// Address region table: TABLE_ENTRIES regions held in a chain of cells, one entry per
// cell. A request walks the chain one cell per cycle, and its result is registered at
// the output once it leaves the last cell. Only one request is in flight at a time.
// The input stays closed until the result has been taken, so a stalled result stalls
// the input.
// Depends on art_pkg and art_cell.
module address_region_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // space_id[15:0], base_addr[63:16], region_len[111:64]
  input  logic [1:0]   in_tuser,  // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata  // status[1:0], hit[2], zero fill
);
  import art_pkg::*;

  art_token_t head_tok;
  art_token_t chain [TABLE_ENTRIES];
  art_token_t tail_tok;
  logic       busy_r;
  logic       busy_nxt;
  logic       ovalid_r;
  logic       ovalid_nxt;
  logic [2:0] odata_r;
  logic [2:0] odata_nxt;
  logic [1:0] st;

  assign in_tready = !busy_r && !ovalid_r;

  // Head of the chain takes the accepted request.
  always_comb begin
    head_tok.active     = in_tvalid && in_tready;
    head_tok.kind       = in_tuser;
    head_tok.space_id   = in_tdata[15:0];
    head_tok.base_addr  = in_tdata[63:16];
    head_tok.region_len = in_tdata[111:64];
    head_tok.done       = 1'b0;
    head_tok.hit        = 1'b0;
  end

  // Each cell hands the request to the next one.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      art_cell u_cell (.clk(clk), .rst_n(rst_n), .tok_in(head_tok), .tok_out(chain[g]));
    end else begin : g_link
      art_cell u_cell (.clk(clk), .rst_n(rst_n), .tok_in(chain[g-1]), .tok_out(chain[g]));
    end
  end

  assign tail_tok = chain[TABLE_ENTRIES-1];

  // Result status from the request that left the chain.
  always_comb begin
    unique case (tail_tok.kind)
      KIND_ADD:    st = tail_tok.done ? ST_OK : ST_FULL;
      KIND_DELETE: st = tail_tok.done ? ST_OK : ST_NOMATCH;
      default:     st = ST_OK;
    endcase
  end

  // Busy and result register control.
  always_comb begin
    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (out_tvalid && out_tready) ovalid_nxt = 1'b0;
    if (head_tok.active) busy_nxt = 1'b1;
    if (tail_tok.active) begin
      busy_nxt   = 1'b0;
      ovalid_nxt = 1'b1;
      odata_nxt  = {tail_tok.hit, st};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'b0, odata_r};

endmodule

// File: rtl/core/art_checker.sv
// Port-level checks of the address region table.
// Depends on address_region_table, to which it is bound.
module art_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  // A request is never accepted while a result waits.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  // Input closes right after an accept.
  a_close_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready after accept");
  // No result arrives the cycle after an accept.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid)) else $error("result too early");
  // Hit only with ok status, and status never reserved code.
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3 && !(out_tdata[2] && out_tdata[1:0] != 2'd0)))
    else $error("bad result code");
  // Result holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
endmodule

bind address_region_table art_checker u_art_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: sim/art_checker.sv
// Checker for the address region table: mirrors the region entries, predicts
// the reply of every accepted request and compares it with the result stream.
// Depends on art_pkg.
`timescale 1ns / 1ps

module art_tb_checker #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [7:0]   out_tdata,
  output int           fail_count,
  output int           pending
);
  import art_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
  } reply_t;

  logic [SpaceW-1:0] tbl_space [ENTRIES];
  logic [AddrW-1:0]  tbl_base  [ENTRIES];
  logic [AddrW-1:0]  tbl_len   [ENTRIES];
  reply_t            reply_q   [$];

  // Applies one request to the mirrored table and returns the reply it causes.
  function automatic reply_t apply_request(logic [1:0] kind, logic [SpaceW-1:0] sid,
                                           logic [AddrW-1:0] addr, logic [AddrW-1:0] len);
    reply_t       r;
    logic [AddrW:0] region_end;
    r = '0;
    case (kind)
      KIND_ADD: begin
        r.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_len[i] == '0) begin
            tbl_space[i] = sid;
            tbl_base[i]  = addr;
            tbl_len[i]   = len;
            r.status     = ST_OK;
            break;
          end
        end
      end
      KIND_DELETE: begin
        r.status = ST_NOMATCH;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_len[i] != '0 && tbl_space[i] == sid && tbl_base[i] == addr &&
              tbl_len[i] == len) begin
            tbl_space[i] = '0;
            tbl_base[i]  = '0;
            tbl_len[i]   = '0;
            r.status     = ST_OK;
            break;
          end
        end
      end
      KIND_QUERY: begin
        for (int i = 0; i < ENTRIES; i++) begin
          // The region end is one bit wider, so it never wraps.
          region_end = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
          if (tbl_len[i] != '0 && tbl_space[i] == sid && addr >= tbl_base[i] &&
              {1'b0, addr} < region_end) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_space[i] == sid) begin
            tbl_space[i] = '0;
            tbl_base[i]  = '0;
            tbl_len[i]   = '0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Predict on every accepted request, compare on every accepted result.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_space[i] = '0;
        tbl_base[i]  = '0;
        tbl_len[i]   = '0;
      end
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        reply_q.push_back(apply_request(in_tuser, in_tdata[15:0], in_tdata[63:16],
                                        in_tdata[111:64]));
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.hit    = out_tdata[2];
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result: status=%0d hit=%0d", got.status, got.hit);
        end else begin
          want = reply_q.pop_front();
          if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected status=%0d hit=%0d, got status=%0d hit=%0d",
                       want.status, want.hit, got.status, got.hit);
          end
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

// File: sim/tb_address_region_table.sv
// Testbench top of the address region table: clock, reset, request stimulus
// and result back-pressure; checking happens in art_tb_checker.
// Depends on art_pkg, address_region_table and art_tb_checker.
`timescale 1ns / 1ps

module tb_address_region_table;
  import art_pkg::*;

  localparam int Entries   = 64;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [SpaceW-1:0] sid;
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  len;
  } region_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = KIND_ADD;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  bit           quiet = 1'b0;
  region_t      live_regions [$];

  always #4 clk = ~clk;

  address_region_table #(.TABLE_ENTRIES(Entries)) DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  art_tb_checker #(.ENTRIES(Entries)) u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending
  );

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (cycle_count == 20000)
        hold = 600;
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = rst_n && (quiet || $urandom_range(0, 99) >= 22);
      end
    end
  end

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  function automatic logic [SpaceW-1:0] pick_space();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return SpaceW'($urandom_range(1, 4));
    if (sel == 16) return '0;
    if (sel == 17) return '1;
    return SpaceW'($urandom);
  endfunction

  function automatic logic [AddrW-1:0] pick_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return AddrW'($urandom_range(1, 4096));
    if (sel == 15) return '0;
    if (sel == 16) return '1;
    return rand_addr();
  endfunction

  // Offers one request and holds it until the block takes it.
  task automatic send(logic [1:0] kind, logic [SpaceW-1:0] sid, logic [AddrW-1:0] base,
                      logic [AddrW-1:0] len);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = {len, base, sid};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_ADD && len != '0)
      live_regions.push_back('{sid, base, len});
  endtask

  // One random request; deletes and queries are mostly built around regions that were added.
  task automatic send_random();
    int               sel;
    int               idx;
    region_t          r;
    logic [AddrW-1:0] probe;
    logic [SpaceW-1:0] sid;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      send(KIND_ADD, pick_space(), rand_addr() >> $urandom_range(0, 47), pick_len());
    end else if (sel < 62) begin
      if (live_regions.size() > 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, live_regions.size() - 1);
        r = live_regions[idx];
        live_regions.delete(idx);
        send(KIND_DELETE, r.sid, r.base, r.len);
      end else begin
        send(KIND_DELETE, pick_space(), rand_addr(), pick_len());
      end
    end else if (sel < 94) begin
      if (live_regions.size() > 0 && $urandom_range(0, 9) < 8) begin
        r = live_regions[$urandom_range(0, live_regions.size() - 1)];
        case ($urandom_range(0, 4))
          0: probe = r.base - 1;
          1: probe = r.base;
          2: probe = r.base + r.len - 1;
          3: probe = r.base + r.len;
          default: probe = r.base + ($urandom % r.len);
        endcase
        sid = ($urandom_range(0, 9) == 0) ? pick_space() : r.sid;
        send(KIND_QUERY, sid, probe, rand_addr());
      end else begin
        send(KIND_QUERY, pick_space(), rand_addr(), rand_addr());
      end
    end else begin
      sid = pick_space();
      foreach (live_regions[i])
        if (live_regions[i].sid == sid) live_regions[i].len = '0;
      for (int i = live_regions.size() - 1; i >= 0; i--)
        if (live_regions[i].len == '0) live_regions.delete(i);
      send(KIND_CLEANUP, sid, rand_addr(), rand_addr());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests: field extremes, every kind and the corner cases.
    send(KIND_ADD, 16'd1, '0, 48'd1);
    send(KIND_QUERY, 16'd1, '0, '0);
    send(KIND_QUERY, 16'd1, 48'd1, '1);
    send(KIND_QUERY, 16'd2, '0, '0);
    // Region whose end runs past the 48-bit address range.
    send(KIND_ADD, '1, '1, '1);
    send(KIND_QUERY, '1, '1, '0);
    send(KIND_QUERY, '1, 48'hFFFF_FFFF_FFFE, '0);
    // Zero length add keeps the entry free; zero length delete never matches.
    send(KIND_ADD, 16'd3, 48'h1000, '0);
    send(KIND_QUERY, 16'd3, 48'h1000, '0);
    send(KIND_DELETE, 16'd3, 48'h1000, '0);
    send(KIND_DELETE, 16'd1, '0, 48'd2);
    send(KIND_DELETE, 16'd1, '0, 48'd1);
    send(KIND_QUERY, 16'd1, '0, '0);
    // Space id zero behaves like any other id.
    send(KIND_ADD, '0, 48'h5555_5555_5555, 48'h2AAA_AAAA_AAAA);
    send(KIND_QUERY, '0, 48'h7FFF_FFFF_FFFE, '0);
    send(KIND_CLEANUP, '0, '0, '0);
    send(KIND_QUERY, '0, 48'h5555_5555_5555, '0);
    // Cleanup of a space with no entries, then of space all-ones with its entry.
    send(KIND_CLEANUP, 16'h1234, '1, '1);
    send(KIND_CLEANUP, '1, '0, '0);
    live_regions.delete();

    for (int n = 0; n < 800; n++) begin
      quiet = (n >= 100 && n < 250);
      if (n == 400) begin
        // Overfill the table, then clear spaces 1 to 4 from it.
        for (int k = 0; k < 70; k++)
          send(KIND_ADD, SpaceW'($urandom_range(1, 4)), rand_addr(), pick_len());
        for (int s = 1; s <= 4; s++)
          send(KIND_CLEANUP, SpaceW'(s), '0, '0);
        live_regions.delete();
      end
      if (n == 600) begin
        in_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_random();
    end
    in_tvalid = 1'b0;
    quiet = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (Entries + 20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/art_pkg.sv
rtl/core/art_cell.sv
rtl/core/address_region_table.sv
rtl/core/art_checker.sv
sim/art_checker.sv
sim/tb_address_region_table.sv
